>>> hw/rtl/d2e_pkg.sv
// d2e_pkg: shared types, constants and the month table for the date to epoch converter
// no dependencies; imported by d2e_ctrl, d2e_datapath and date_to_epoch_seconds

package d2e_pkg;

   // epoch origin and the leap-rule phase of the epoch year
   localparam logic [11:0] EPOCH_YEAR         = 12'd1970;
   localparam logic [6:0]  EPOCH_YEAR_MOD100  = 7'd70;
   localparam logic [1:0]  EPOCH_CENTURY_MOD4 = 2'd3;
   localparam logic [6:0]  LAST_YEAR_OF_CENT  = 7'd99;

   // seconds per unit
   localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
   localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
   localparam logic [16:0] SECS_PER_DAY     = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
   localparam logic [5:0]  SECS_PER_MINUTE  = 6'd60;

   // divide by 100 through a reciprocal: q = (year * 5243) >> 19, exact for 12-bit years
   localparam logic [12:0] RECIP_100       = 13'd5243;
   localparam int          RECIP_100_SHIFT = 19;
   localparam logic [11:0] CENTURY_YEARS   = 12'd100;

   // month codes
   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_LEAP,
      ST_YEAR,
      ST_DATE,
      ST_SUM,
      ST_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic prep;
      logic leap;
      logic year_step;
      logic date;
      logic sum;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic years_done;
   } dp_status_type;

   // days in the months before month m, february counted as 28
   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] d;
      unique case (m)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

>>> hw/rtl/d2e_ctrl.sv
// d2e_ctrl: sequencer for the date to epoch converter
// depends on d2e_pkg; drives d2e_datapath through dp_cmd_type

module d2e_ctrl
   import d2e_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          rsp_valid
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_PREP;
         end
         ST_PREP: state_in = ST_LEAP;
         ST_LEAP: state_in = ST_YEAR;
         ST_YEAR: begin
            if (status.years_done) state_in = ST_DATE;
         end
         ST_DATE: state_in = ST_SUM;
         ST_SUM:  state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_PREP: cmd.prep = 1'b1;
         ST_LEAP: cmd.leap = 1'b1;
         ST_YEAR: cmd.year_step = !status.years_done;
         ST_DATE: cmd.date = 1'b1;
         ST_SUM:  cmd.sum = 1'b1;
         ST_DONE: rsp_valid = 1'b1;
         default: busy = 1'b0;
      endcase
   end

   // result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // the year loop holds until the datapath reports completion
   a_year_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YEAR && !status.years_done) |=> (state_ff == ST_YEAR))
      else $error("year loop left early");

   // a result comes only from the final sum
   a_result_after_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.sum))
      else $error("result strobe without a preceding sum");

endmodule

>>> hw/rtl/d2e_datapath.sv
// d2e_datapath: input registers, year accumulator, leap logic and date/time products
// depends on d2e_pkg; commanded by d2e_ctrl

module d2e_datapath
   import d2e_pkg::*;
(
   input  logic          clock,
   input  dp_cmd_type    cmd,
   input  logic [11:0]   req_year,
   input  logic [3:0]    req_month,
   input  logic [4:0]    req_day,
   input  logic [4:0]    req_hour,
   input  logic [5:0]    req_minute,
   input  logic [5:0]    req_second,
   output dp_status_type status,
   output logic [31:0]   rsp_epoch_seconds
);

   logic [11:0] year_ff;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff;

   logic [11:0] y_ff;
   logic [6:0]  mod100_ff;
   logic [1:0]  cent_ff;
   logic [31:0] total_ff;
   logic [5:0]  quot_ff;
   logic        leap_ff;
   logic [16:0] time_ff;
   logic [24:0] dprod_ff;

   logic [24:0] qprod;
   logic [11:0] hundreds;
   logic        leap_in;
   logic        leap_y;
   logic [16:0] time_in;
   logic        month_ok;
   logic [8:0]  day_m1;
   logic [8:0]  days;
   logic [24:0] dprod_in;

   // divide year by 100 through the reciprocal, and time of day in seconds
   assign qprod   = 25'(year_ff) * 25'(RECIP_100);
   assign time_in = 17'(hour_ff) * 17'(SECS_PER_HOUR)
                  + 17'(minute_ff) * 17'(SECS_PER_MINUTE)
                  + 17'(second_ff);

   // full leap rule for the requested year
   assign hundreds = 12'(quot_ff) * CENTURY_YEARS;
   assign leap_in  = (year_ff[1:0] == 2'b00)
                   && ((year_ff != hundreds) || (quot_ff[1:0] == 2'b00));

   // leap rule for the loop year from its running residues
   assign leap_y = (y_ff[1:0] == 2'b00) && ((mod100_ff != 7'd0) || (cent_ff == 2'd0));

   // days elapsed in the current year
   assign month_ok = (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC);
   assign day_m1   = (day_ff == 5'd0) ? 9'd0 : 9'(day_ff - 5'd1);
   always_comb begin
      days = 9'd0;
      if (month_ok) begin
         days = days_before_month(month_ff) + day_m1
              + 9'((month_ff > MONTH_FEB) && leap_ff);
      end
   end
   assign dprod_in = 25'(days) * 25'(SECS_PER_DAY);

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         year_ff   <= req_year;
         month_ff  <= req_month;
         day_ff    <= req_day;
         hour_ff   <= req_hour;
         minute_ff <= req_minute;
         second_ff <= req_second;
      end
   end

   // first-stage products, leap flag and the day product
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         quot_ff <= qprod[RECIP_100_SHIFT +: 6];
         time_ff <= time_in;
      end
      if (cmd.leap) begin
         leap_ff <= leap_in;
      end
      if (cmd.date) begin
         dprod_ff <= dprod_in;
      end
   end

   // year loop counters and accumulator
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         y_ff      <= EPOCH_YEAR;
         mod100_ff <= EPOCH_YEAR_MOD100;
         cent_ff   <= EPOCH_CENTURY_MOD4;
         total_ff  <= 32'd0;
      end else if (cmd.year_step) begin
         y_ff     <= y_ff + 12'd1;
         total_ff <= total_ff + (leap_y ? SECS_LEAP_YEAR : SECS_COMMON_YEAR);
         if (mod100_ff == LAST_YEAR_OF_CENT) begin
            mod100_ff <= 7'd0;
            cent_ff   <= cent_ff + 2'd1;
         end else begin
            mod100_ff <= mod100_ff + 7'd1;
         end
      end else if (cmd.sum) begin
         total_ff <= total_ff + 32'(dprod_ff) + 32'(time_ff);
      end
   end

   assign status.years_done = (y_ff >= year_ff);
   assign rsp_epoch_seconds = total_ff;

endmodule

>>> hw/rtl/date_to_epoch_seconds.sv
// date_to_epoch_seconds: Gregorian date and time of day to seconds since 1970-01-01 00:00:00
// the sequencer steps from accept through prep, leap, the year loop, date and sum to the
// result strobe; the year loop adds one whole year per cycle in a single accumulator
// a new transaction is taken only once the sequencer is back in idle; busy is high until
// then, results are strobed for one cycle and cannot be stalled
// reset clears the sequencer to idle; depends on d2e_pkg, d2e_ctrl, d2e_datapath

module date_to_epoch_seconds
   import d2e_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   output logic        rsp_valid,
   output logic [31:0] rsp_epoch_seconds
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   d2e_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // arithmetic
   d2e_datapath u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day           (req_day),
      .req_hour          (req_hour),
      .req_minute        (req_minute),
      .req_second        (req_second),
      .status            (status),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

endmodule

>>> dv/date_to_epoch_seconds_test.sv
`timescale 1ns / 100ps
// date_to_epoch_seconds_test: self-checking bench for the date to epoch seconds converter
// drives dates over start/busy, checks each strobed result in a scoreboard class
// depends on d2e_pkg and date_to_epoch_seconds

module date_to_epoch_seconds_test;
   import d2e_pkg::*;

   localparam int unsigned FIRST_YEAR   = 1970;
   localparam int unsigned LEAP_SECS    = 366 * 86400;
   localparam int unsigned COMMON_SECS  = 365 * 86400;
   localparam int          RANDOM_ITEMS = 950;
   localparam int          QUIET_TAIL   = 150;
   localparam int          STALL_LIMIT  = 20000;

   // days in the months before month m, february taken as 28
   localparam int unsigned DAYS_BEFORE[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243,
                                               273, 304, 334};

   // expected epoch seconds for each accepted date, oldest first
   class epoch_scoreboard;
      logic [31:0] pending_epochs[$];
      int unsigned results_checked;
      int unsigned mismatches;

      function bit leap_rule(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      function logic [31:0] epoch_of(logic [11:0] yr, logic [3:0] mo, logic [4:0] dy,
                                     logic [4:0] hr, logic [5:0] mi, logic [5:0] sc);
         logic [31:0] total;
         logic [31:0] days;
         total = '0;
         days  = '0;
         // whole years since the epoch, none for years before it
         for (int unsigned y = FIRST_YEAR; y < yr; y++)
            total += leap_rule(y) ? LEAP_SECS : COMMON_SECS;
         // completed months and elapsed days, only for a real month
         if (mo >= MONTH_JAN && mo <= MONTH_DEC) begin
            days = DAYS_BEFORE[mo];
            if (mo > MONTH_FEB && leap_rule(yr)) days += 1;
            if (dy != 0) days += dy - 1;
         end
         total += days * 32'd86400;
         total += hr * 32'd3600 + mi * 32'd60 + sc;
         return total;
      endfunction

      function void note_date(logic [11:0] yr, logic [3:0] mo, logic [4:0] dy,
                              logic [4:0] hr, logic [5:0] mi, logic [5:0] sc);
         pending_epochs.push_back(epoch_of(yr, mo, dy, hr, mi, sc));
      endfunction

      function void check_epoch(logic [31:0] actual);
         logic [31:0] expected;
         if (pending_epochs.size() == 0) begin
            mismatches++;
            $display("%0t: result %0d strobed with no transaction outstanding", $time, actual);
            return;
         end
         expected = pending_epochs.pop_front();
         results_checked++;
         if (actual !== expected) begin
            mismatches++;
            $display("%0t: epoch_seconds mismatch, expected %0d actual %0d",
                     $time, expected, actual);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [11:0] req_year;
   logic [3:0]  req_month;
   logic [4:0]  req_day;
   logic [4:0]  req_hour;
   logic [5:0]  req_minute;
   logic [5:0]  req_second;
   logic        rsp_valid;
   logic [31:0] rsp_epoch_seconds;

   epoch_scoreboard sb;
   int unsigned     dates_sent;
   int unsigned     quiet_cycles = 0;

   date_to_epoch_seconds DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day           (req_day),
      .req_hour          (req_hour),
      .req_minute        (req_minute),
      .req_second        (req_second),
      .rsp_valid         (rsp_valid),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // monitor: a result at an accept edge belongs to the earlier transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_epoch(rsp_epoch_seconds);
         if (start && !busy)
            sb.note_date(req_year, req_month, req_day, req_hour, req_minute, req_second);
      end
   end

   // watchdog on cycles with neither an accept nor a result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // one transaction, held until the block takes it
   task automatic send_date(input logic [11:0] yr, input logic [3:0] mo, input logic [4:0] dy,
                            input logic [4:0] hr, input logic [5:0] mi, input logic [5:0] sc);
      @(negedge clock);
      req_year   <= yr;
      req_month  <= mo;
      req_day    <= dy;
      req_hour   <= hr;
      req_minute <= mi;
      req_second <= sc;
      start      <= 1'b1;
      do @(posedge clock); while (busy);
      dates_sent++;
   endtask

   task automatic idle_burst(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // hold off until every expected result has been checked
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_epochs.size() != 0) @(negedge clock);
   endtask

   initial begin
      int unsigned directed_count;
      int unsigned pick;
      logic [11:0] yr;
      logic [3:0]  mo;
      logic [4:0]  dy;
      logic [4:0]  hr;
      logic [5:0]  mi;
      logic [5:0]  sc;

      sb         = new();
      dates_sent = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_year   = '0;
      req_month  = '0;
      req_day    = '0;
      req_hour   = '0;
      req_minute = '0;
      req_second = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // epoch origin and last second of the valid range
      send_date(12'd1970, MONTH_JAN, 5'd1, 5'd0, 6'd0, 6'd0);
      send_date(12'd2105, MONTH_DEC, 5'd31, 5'd23, 6'd59, 6'd59);
      // every month, odd months in a 400-year leap year and even months in a non-leap century year
      for (int m = 1; m <= 12; m++)
         send_date((m % 2) ? 12'd2000 : 12'd2100, 4'(m), 5'd28, 5'd12, 6'd30, 6'd45);
      // leap day
      send_date(12'd2024, MONTH_FEB, 5'd29, 5'd6, 6'd7, 6'd8);
      // year before the epoch, its own february still leap
      send_date(12'd1968, 4'd3, 5'd1, 5'd0, 6'd0, 6'd1);
      // year zero
      send_date(12'd0, MONTH_JAN, 5'd1, 5'd0, 6'd0, 6'd0);
      // every field at its all-ones value, sum wraps
      send_date(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
      // month zero
      send_date(12'd2000, 4'd0, 5'd10, 5'd1, 6'd2, 6'd3);
      // day zero
      send_date(12'd1999, 4'd5, 5'd0, 5'd4, 6'd5, 6'd6);
      // day beyond the month's length
      send_date(12'd2023, MONTH_FEB, 5'd31, 5'd0, 6'd0, 6'd0);
      // time of day out of range
      send_date(12'd1980, 4'd6, 5'd15, 5'd31, 6'd63, 6'd63);
      directed_count = dates_sent;
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 300 || i == 650) drain_results();
         if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            idle_burst($urandom_range(1, 7));
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            // well-formed dates in the supported range
            yr = 12'($urandom_range(1970, 2105));
            mo = 4'($urandom_range(1, 12));
            dy = 5'($urandom_range(1, 31));
            hr = 5'($urandom_range(0, 23));
            mi = 6'($urandom_range(0, 59));
            sc = 6'($urandom_range(0, 59));
         end else begin
            // any field value, with a few full-width years
            yr = (pick < 97) ? 12'($urandom_range(0, 2200)) : 12'($urandom_range(0, 4095));
            mo = 4'($urandom_range(0, 15));
            dy = 5'($urandom_range(0, 31));
            hr = 5'($urandom_range(0, 31));
            mi = 6'($urandom_range(0, 63));
            sc = 6'($urandom_range(0, 63));
         end
         send_date(yr, mo, dy, hr, mi, sc);
      end

      drain_results();
      repeat (16) @(posedge clock);

      $display("%0d transactions sent (%0d directed), %0d results checked",
               dates_sent, directed_count, sb.results_checked);
      $display("covered leap and century years, every month, bad fields, years 0 to 4095");
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
